FILE: rtl/assert_macros.svh
// assertion macros shared by the splat core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/agvs_pkg.sv
// shared constants, command/status types and weight table function for the splat core
package agvs_pkg;

   // default configuration
   localparam int GRID_SIZE_DEF     = 32;
   localparam int NUM_TYPES_DEF     = 11;
   localparam int SPREAD_RADIUS_DEF = 2;
   localparam int SPREAD_RADIUS_MAX = 4;

   // field widths
   localparam int POS_W    = 16;
   localparam int FRAC_W   = 8;
   localparam int TYPE_W   = 4;
   localparam int IDX_W    = 5;
   localparam int VOXEL_W  = 24;
   localparam int WEIGHT_W = 16;

   // signed cell index, covers floor(pos) plus or minus the largest radius
   localparam int CELL_W = 10;
   // neighbourhood offset counter, 0 .. 2*radius
   localparam int OFF_W  = $clog2(2 * SPREAD_RADIUS_MAX + 1);

   // squared distance rounded to 1/16: (r2 + half) >> shift
   localparam int RND_SHIFT = 12;
   localparam int RND_HALF  = 2048;

   localparam logic [VOXEL_W-1:0]  VOXEL_MAX    = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = '1;
   localparam logic [63:0]         EXP_STEP_Q32 = 64'd4162825044;

   // item kinds
   localparam logic KIND_SPLAT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             clear;
      logic             step;
      logic [OFF_W-1:0] off_i;
      logic [OFF_W-1:0] off_j;
      logic [OFF_W-1:0] off_k;
      logic             rd_issue;
      logic             rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic pipe_busy;
      logic rsp_free;
   } status_type;

   // exp(-n/32) in Q0.16, saturated, by repeated Q0.32 multiplication
   function automatic logic [WEIGHT_W-1:0] weight_calc(input int n);
      logic [63:0] p;
      logic [63:0] w;
      p = 64'h1_0000_0000;
      for (int m = 0; m < n; m++) begin
         p = (p * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
      w = (p + 64'd32768) >> 16;
      return (w > 64'(WEIGHT_MAX)) ? WEIGHT_MAX : w[WEIGHT_W-1:0];
   endfunction

endpackage

FILE: rtl/agvs_ctrl.sv
// sequencer for clearing, neighbourhood walk, drain and voxel reads
`include "assert_macros.svh"

module agvs_ctrl
   import agvs_pkg::*;
#(
   parameter int SPREAD_RADIUS = SPREAD_RADIUS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_stall,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(2 * SPREAD_RADIUS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPLAT,
      ST_DRAIN,
      ST_READ,
      ST_RESPOND
   } state_type;

   state_type        state_ff;
   logic [OFF_W-1:0] off_i_ff;
   logic [OFF_W-1:0] off_j_ff;
   logic [OFF_W-1:0] off_k_ff;
   logic             accept;

   // input beat taken only when idle
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.step     = (state_ff == ST_SPLAT);
      cmd.off_i    = off_i_ff;
      cmd.off_j    = off_j_ff;
      cmd.off_k    = off_k_ff;
      cmd.rd_issue = (state_ff == ST_READ);
      cmd.rsp_load = (state_ff == ST_RESPOND) && status.rsp_free;
   end

   // state and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         off_i_ff <= '0;
         off_j_ff <= '0;
         off_k_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_done) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_kind)
                     KIND_SPLAT: begin
                        state_ff <= ST_SPLAT;
                        off_i_ff <= '0;
                        off_j_ff <= '0;
                        off_k_ff <= '0;
                     end
                     KIND_READ: begin
                        state_ff <= ST_READ;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_SPLAT: begin
               if (off_k_ff == OFF_LAST) begin
                  off_k_ff <= '0;
                  if (off_j_ff == OFF_LAST) begin
                     off_j_ff <= '0;
                     if (off_i_ff == OFF_LAST) begin
                        off_i_ff <= '0;
                        state_ff <= ST_DRAIN;
                     end else begin
                        off_i_ff <= off_i_ff + OFF_W'(1);
                     end
                  end else begin
                     off_j_ff <= off_j_ff + OFF_W'(1);
                  end
               end else begin
                  off_k_ff <= off_k_ff + OFF_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!status.pipe_busy) state_ff <= ST_IDLE;
            end
            ST_READ: begin
               state_ff <= ST_RESPOND;
            end
            ST_RESPOND: begin
               if (status.rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   `ASSERT_NEXT(a_read_then_respond, cmd.rd_issue, state_ff == ST_RESPOND, "read issue not followed by respond")
   `ASSERT_NEVER(a_off_range, off_i_ff > OFF_LAST || off_j_ff > OFF_LAST || off_k_ff > OFF_LAST, "walk offset out of range")
   `ASSERT_IMPL(a_clear_end, $fell(cmd.clear), $past(status.clear_done), "clearing pass ended early")

endmodule

FILE: rtl/agvs_datapath.sv
// density store, distance and weight pipeline, read-modify-write and result register
`include "assert_macros.svh"

module agvs_datapath
   import agvs_pkg::*;
#(
   parameter int GRID_SIZE     = GRID_SIZE_DEF,
   parameter int NUM_TYPES     = NUM_TYPES_DEF,
   parameter int SPREAD_RADIUS = SPREAD_RADIUS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic        [TYPE_W-1:0]   req_splat_grid,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,
   input  logic signed [POS_W-1:0]    req_pos_z,
   input  logic        [TYPE_W-1:0]   req_read_type,
   input  logic        [IDX_W-1:0]    req_read_i,
   input  logic        [IDX_W-1:0]    req_read_j,
   input  logic        [IDX_W-1:0]    req_read_k,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic        [VOXEL_W-1:0]  rsp_voxel_value
);

   localparam int GB           = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
   localparam int TB           = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int MEM_DEPTH    = NUM_TYPES * (1 << (3 * GB));
   localparam int ADDR_W       = $clog2(MEM_DEPTH);
   localparam int DW           = $clog2((SPREAD_RADIUS + 1) * 256) + 1;
   localparam int SQ_W         = 2 * DW - 1;
   localparam int R2_W         = SQ_W + 2;
   localparam int WEIGHT_DEPTH = 3 * (SPREAD_RADIUS + 1) * (SPREAD_RADIUS + 1) * 16 + 1;
   localparam int WIDX_W       = $clog2(WEIGHT_DEPTH);

   // cell index of one axis: floor(pos) + off - radius
   function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [POS_W-1:0] pos,
                                                        input logic [OFF_W-1:0] off);
      logic signed [CELL_W-1:0] c;
      c = CELL_W'($signed(pos[POS_W-1:FRAC_W]));
      return c + $signed(CELL_W'(off)) - $signed(CELL_W'(SPREAD_RADIUS));
   endfunction

   // distance of one axis: frac - 256 * (off - radius)
   function automatic logic signed [DW-1:0] dist_of(input logic [FRAC_W-1:0] frac,
                                                    input logic [OFF_W-1:0] off);
      logic signed [DW-1:0] rel;
      rel = $signed(DW'(off)) - $signed(DW'(SPREAD_RADIUS));
      return $signed(DW'(frac)) - (rel <<< FRAC_W);
   endfunction

   function automatic logic in_grid(input logic signed [CELL_W-1:0] c);
      return (c >= $signed(CELL_W'(0))) && (c < $signed(CELL_W'(GRID_SIZE)));
   endfunction

   // latched item
   logic        [TYPE_W-1:0] type_ff;
   logic signed [POS_W-1:0]  pos_x_ff;
   logic signed [POS_W-1:0]  pos_y_ff;
   logic signed [POS_W-1:0]  pos_z_ff;
   logic        [TYPE_W-1:0] rd_type_ff;
   logic        [IDX_W-1:0]  rd_i_ff;
   logic        [IDX_W-1:0]  rd_j_ff;
   logic        [IDX_W-1:0]  rd_k_ff;

   // weight table
   logic [WEIGHT_W-1:0] weight_rom [WEIGHT_DEPTH];

   // density store
   logic [VOXEL_W-1:0] density_mem [MEM_DEPTH];
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [VOXEL_W-1:0] mem_rd_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   // stage 0 signals
   logic signed [CELL_W-1:0] cell_i;
   logic signed [CELL_W-1:0] cell_j;
   logic signed [CELL_W-1:0] cell_k;
   logic                     type_ok;
   logic                     s1_valid_in;
   logic [ADDR_W-1:0]        s1_addr_in;

   // pipeline registers
   logic                 s1_valid_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic signed [DW-1:0] s1_dx_ff;
   logic signed [DW-1:0] s1_dy_ff;
   logic signed [DW-1:0] s1_dz_ff;

   logic signed [2*DW-1:0] prod_x;
   logic signed [2*DW-1:0] prod_y;
   logic signed [2*DW-1:0] prod_z;

   logic              s2_valid_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [SQ_W-1:0]   s2_sq_x_ff;
   logic [SQ_W-1:0]   s2_sq_y_ff;
   logic [SQ_W-1:0]   s2_sq_z_ff;

   logic [R2_W-1:0]   r2_rnd;
   logic              s3_valid_ff;
   logic [ADDR_W-1:0] s3_addr_ff;
   logic [WIDX_W-1:0] s3_n_ff;

   logic                s4_valid_ff;
   logic [ADDR_W-1:0]   s4_addr_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic [VOXEL_W:0]   acc_sum;
   logic [VOXEL_W-1:0] acc_sat;

   // read item decode
   logic [CELL_W-1:0] rd_i_ext;
   logic [CELL_W-1:0] rd_j_ext;
   logic [CELL_W-1:0] rd_k_ext;
   logic              rd_ok;
   logic [ADDR_W-1:0] rd_item_addr;

   // result register
   logic               rsp_valid_ff;
   logic [VOXEL_W-1:0] rsp_value_ff;

   // weight table built at elaboration
   for (genvar g = 0; g < WEIGHT_DEPTH; g++) begin : g_weight
      localparam logic [WEIGHT_W-1:0] W_G = weight_calc(g);
      assign weight_rom[g] = W_G;
   end

   // latch item fields on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff    <= req_splat_grid;
         pos_x_ff   <= req_pos_x;
         pos_y_ff   <= req_pos_y;
         pos_z_ff   <= req_pos_z;
         rd_type_ff <= req_read_type;
         rd_i_ff    <= req_read_i;
         rd_j_ff    <= req_read_j;
         rd_k_ff    <= req_read_k;
      end
   end

   // stage 0: cell of the current offset, bounds and address
   always_comb begin
      cell_i      = cell_of(pos_x_ff, cmd.off_i);
      cell_j      = cell_of(pos_y_ff, cmd.off_j);
      cell_k      = cell_of(pos_z_ff, cmd.off_k);
      type_ok     = ((TYPE_W + 1)'(type_ff) < (TYPE_W + 1)'(NUM_TYPES));
      s1_valid_in = cmd.step && type_ok && in_grid(cell_i) && in_grid(cell_j) && in_grid(cell_k);
      s1_addr_in  = ADDR_W'({type_ff[TB-1:0], cell_i[GB-1:0], cell_j[GB-1:0], cell_k[GB-1:0]});
   end

   // stage 1: per-axis distances
   always_ff @(posedge clock) begin
      s1_addr_ff <= s1_addr_in;
      s1_dx_ff   <= dist_of(pos_x_ff[FRAC_W-1:0], cmd.off_i);
      s1_dy_ff   <= dist_of(pos_y_ff[FRAC_W-1:0], cmd.off_j);
      s1_dz_ff   <= dist_of(pos_z_ff[FRAC_W-1:0], cmd.off_k);
   end

   // stage 2: squares
   assign prod_x = s1_dx_ff * s1_dx_ff;
   assign prod_y = s1_dy_ff * s1_dy_ff;
   assign prod_z = s1_dz_ff * s1_dz_ff;

   always_ff @(posedge clock) begin
      s2_addr_ff <= s1_addr_ff;
      s2_sq_x_ff <= prod_x[SQ_W-1:0];
      s2_sq_y_ff <= prod_y[SQ_W-1:0];
      s2_sq_z_ff <= prod_z[SQ_W-1:0];
   end

   // stage 3: squared distance rounded to table index
   assign r2_rnd = R2_W'(s2_sq_x_ff) + R2_W'(s2_sq_y_ff) + R2_W'(s2_sq_z_ff)
                 + R2_W'(RND_HALF);

   always_ff @(posedge clock) begin
      s3_addr_ff <= s2_addr_ff;
      s3_n_ff    <= r2_rnd[RND_SHIFT +: WIDX_W];
   end

   // stage 4: weight lookup alongside the voxel read
   always_ff @(posedge clock) begin
      s4_addr_ff <= s3_addr_ff;
      weight_ff  <= weight_rom[s3_n_ff];
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // read item address and range check
   always_comb begin
      rd_i_ext     = CELL_W'(rd_i_ff);
      rd_j_ext     = CELL_W'(rd_j_ff);
      rd_k_ext     = CELL_W'(rd_k_ff);
      rd_ok        = ((TYPE_W + 1)'(rd_type_ff) < (TYPE_W + 1)'(NUM_TYPES))
                  && (rd_i_ext < CELL_W'(GRID_SIZE))
                  && (rd_j_ext < CELL_W'(GRID_SIZE))
                  && (rd_k_ext < CELL_W'(GRID_SIZE));
      rd_item_addr = ADDR_W'({rd_type_ff[TB-1:0], rd_i_ext[GB-1:0], rd_j_ext[GB-1:0],
                              rd_k_ext[GB-1:0]});
   end

   // shared read port
   assign rd_en   = s3_valid_ff || cmd.rd_issue;
   assign rd_addr = cmd.rd_issue ? rd_item_addr : s3_addr_ff;

   always_ff @(posedge clock) begin
      if (rd_en) mem_rd_ff <= density_mem[rd_addr];
   end

   // saturating accumulate
   always_comb begin
      acc_sum = {1'b0, mem_rd_ff} + (VOXEL_W + 1)'(weight_ff);
      acc_sat = acc_sum[VOXEL_W] ? VOXEL_MAX : acc_sum[VOXEL_W-1:0];
   end

   // write port: clearing pass or accumulate
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         density_mem[clr_addr_ff] <= '0;
      end else if (s4_valid_ff) begin
         density_mem[s4_addr_ff] <= acc_sat;
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= status.clear_done ? '0 : clr_addr_ff + ADDR_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_value_ff <= rd_ok ? mem_rd_ff : '0;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voxel_value = rsp_value_ff;

   // status back to the controller
   always_comb begin
      status            = '0;
      status.clear_done = (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1));
      status.pipe_busy  = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // checks
   `ASSERT_NEVER(a_write_in_clear, s4_valid_ff && cmd.clear, "accumulate write during clearing pass")
   `ASSERT_NEVER(a_read_conflict, s3_valid_ff && cmd.rd_issue, "voxel read collides with splat read")
   `ASSERT_NEXT(a_rsp_loaded, cmd.rsp_load, rsp_valid_ff, "result load did not raise rsp_valid")

endmodule

FILE: rtl/atom_gaussian_voxel_splat_core.sv
// top level of the gaussian voxel splat core: controller plus datapath
//
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  kind, splat_grid, pos_x/y/z, read_type, read_i/j/k
// rsp      out  rsp_valid / rsp_stall  voxel_value (one beat per read, none per splat)
//
// a splat beat walks the (2*SPREAD_RADIUS+1)^3 neighbourhood with one voxel
// read-modify-write per cycle on the shared read port, plus pipeline drain; the drain
// is shorter when the tail of the walk falls off the grid.
// a read beat issues its voxel read, then waits while the previous result is stalled.
// after reset a clearing pass writes NUM_TYPES * 2^(3*ceil(log2 GRID_SIZE)) voxels,
// one a cycle; req_stall stays high until it ends.
// a waiting result does not block the next splat beat.
module atom_gaussian_voxel_splat_core
   import agvs_pkg::*;
#(
   parameter int GRID_SIZE     = GRID_SIZE_DEF,
   parameter int NUM_TYPES     = NUM_TYPES_DEF,
   parameter int SPREAD_RADIUS = SPREAD_RADIUS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic        [TYPE_W-1:0]  req_splat_grid,
   input  logic signed [POS_W-1:0]   req_pos_x,
   input  logic signed [POS_W-1:0]   req_pos_y,
   input  logic signed [POS_W-1:0]   req_pos_z,
   input  logic        [TYPE_W-1:0]  req_read_type,
   input  logic        [IDX_W-1:0]   req_read_i,
   input  logic        [IDX_W-1:0]   req_read_j,
   input  logic        [IDX_W-1:0]   req_read_k,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [VOXEL_W-1:0] rsp_voxel_value
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   agvs_ctrl #(
      .SPREAD_RADIUS (SPREAD_RADIUS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // store and arithmetic
   agvs_datapath #(
      .GRID_SIZE     (GRID_SIZE),
      .NUM_TYPES     (NUM_TYPES),
      .SPREAD_RADIUS (SPREAD_RADIUS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_splat_grid  (req_splat_grid),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_read_type   (req_read_type),
      .req_read_i      (req_read_i),
      .req_read_j      (req_read_j),
      .req_read_k      (req_read_k),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_voxel_value (rsp_voxel_value)
   );

endmodule

FILE: test/atom_gaussian_voxel_splat_core_tb.sv
// self-checking testbench for the gaussian voxel splat core, mirrored density grids
`timescale 1ns / 100ps

module atom_gaussian_voxel_splat_core_tb;
   import agvs_pkg::*;

   localparam int GRID         = GRID_SIZE_DEF;
   localparam int TYPES        = NUM_TYPES_DEF;
   localparam int RADIUS       = SPREAD_RADIUS_DEF;
   localparam int CELL_ONE     = 1 << FRAC_W;
   localparam int STORE_DEPTH  = TYPES * GRID * GRID * GRID;
   localparam int WEIGHT_DEPTH = 3 * (RADIUS + 1) * (RADIUS + 1) * 16 + 1;
   localparam int DIST_HALF    = 2048;
   localparam int DIST_SHIFT   = 12;
   localparam logic [63:0] DECAY_Q32 = 64'd4162825044;
   localparam int HOT_LO         = GRID / 2 - 4;
   localparam int RESET_CYCLES   = 11;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 300;
   // the limit outlasts the clearing pass, during which no beat is taken
   localparam int WATCHDOG_LIMIT = 1_500_000;

   typedef struct packed {
      logic              kind;
      logic [TYPE_W-1:0] splat_grid;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic [TYPE_W-1:0] read_type;
      logic [IDX_W-1:0]  read_i;
      logic [IDX_W-1:0]  read_j;
      logic [IDX_W-1:0]  read_k;
   } voxel_cmd_type;

   typedef struct packed {
      int t;
      int x;
      int y;
      int z;
   } site_type;

   typedef enum int {
      PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH_IDLE, PH_PRESSURE
   } phase_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_kind = KIND_SPLAT;
   logic        [TYPE_W-1:0] req_splat_grid = '0;
   logic signed [POS_W-1:0]  req_pos_x = '0;
   logic signed [POS_W-1:0]  req_pos_y = '0;
   logic signed [POS_W-1:0]  req_pos_z = '0;
   logic        [TYPE_W-1:0] req_read_type = '0;
   logic        [IDX_W-1:0]  req_read_i = '0;
   logic        [IDX_W-1:0]  req_read_j = '0;
   logic        [IDX_W-1:0]  req_read_k = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic       [VOXEL_W-1:0] rsp_voxel_value;

   phase_type phase = PH_STEADY;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // mirrored density grids and the gaussian weight table
   bit [VOXEL_W-1:0]  density_mirror [STORE_DEPTH];
   bit [WEIGHT_W-1:0] gauss_weight [WEIGHT_DEPTH];

   voxel_cmd_type      pending_beats [$];
   logic [VOXEL_W-1:0] expected_voxels [$];
   site_type           recent_sites [$];
   voxel_cmd_type      on_bus;
   logic [VOXEL_W-1:0] voxel_want;

   int mismatch_count  = 0;
   int splats_accepted = 0;
   int reads_accepted  = 0;
   int voxels_checked  = 0;
   int saturated_seen  = 0;
   int quiet_cycles    = 0;
   int hold_cnt        = 0;

   atom_gaussian_voxel_splat_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_splat_grid  (req_splat_grid),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_read_type   (req_read_type),
      .req_read_i      (req_read_i),
      .req_read_j      (req_read_j),
      .req_read_k      (req_read_k),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_voxel_value (rsp_voxel_value)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // add one atom's gaussian to its type's grid, saturating per voxel
   function automatic void deposit_atom(input logic [TYPE_W-1:0] t,
                                        input logic signed [POS_W-1:0] px,
                                        input logic signed [POS_W-1:0] py,
                                        input logic signed [POS_W-1:0] pz);
      int cx, cy, cz, i, j, k, dx, dy, dz, n, idx;
      logic [VOXEL_W:0] sum;
      if (int'(t) >= TYPES) return;
      cx = int'(px) >>> FRAC_W;
      cy = int'(py) >>> FRAC_W;
      cz = int'(pz) >>> FRAC_W;
      for (i = cx - RADIUS; i <= cx + RADIUS; i++) begin
         for (j = cy - RADIUS; j <= cy + RADIUS; j++) begin
            for (k = cz - RADIUS; k <= cz + RADIUS; k++) begin
               if (i < 0 || i >= GRID || j < 0 || j >= GRID || k < 0 || k >= GRID) continue;
               dx = int'(px) - i * CELL_ONE;
               dy = int'(py) - j * CELL_ONE;
               dz = int'(pz) - k * CELL_ONE;
               n = (dx * dx + dy * dy + dz * dz + DIST_HALF) >> DIST_SHIFT;
               idx = ((int'(t) * GRID + i) * GRID + j) * GRID + k;
               sum = density_mirror[idx] + ((n < WEIGHT_DEPTH) ? gauss_weight[n] : '0);
               density_mirror[idx] = (sum > VOXEL_MAX) ? VOXEL_MAX : sum[VOXEL_W-1:0];
            end
         end
      end
   endfunction

   // voxel a read beat returns; out-of-range selections read as zero
   function automatic logic [VOXEL_W-1:0] lookup_voxel(input voxel_cmd_type c);
      if (int'(c.read_type) >= TYPES || int'(c.read_i) >= GRID || int'(c.read_j) >= GRID ||
          int'(c.read_k) >= GRID) return '0;
      return density_mirror[((int'(c.read_type) * GRID + int'(c.read_i)) * GRID +
                             int'(c.read_j)) * GRID + int'(c.read_k)];
   endfunction

   // every field random, unused ones included
   function automatic voxel_cmd_type scrambled_cmd();
      voxel_cmd_type c;
      c.kind       = 1'($urandom);
      c.splat_grid = TYPE_W'($urandom);
      c.pos_x      = POS_W'($urandom);
      c.pos_y      = POS_W'($urandom);
      c.pos_z      = POS_W'($urandom);
      c.read_type  = TYPE_W'($urandom);
      c.read_i     = IDX_W'($urandom);
      c.read_j     = IDX_W'($urandom);
      c.read_k     = IDX_W'($urandom);
      return c;
   endfunction

   function automatic voxel_cmd_type splat_at(input int t, input int x, input int y, input int z);
      voxel_cmd_type c;
      c = scrambled_cmd();
      c.kind       = KIND_SPLAT;
      c.splat_grid = TYPE_W'(t);
      c.pos_x      = POS_W'(x);
      c.pos_y      = POS_W'(y);
      c.pos_z      = POS_W'(z);
      return c;
   endfunction

   function automatic voxel_cmd_type read_at(input int t, input int i, input int j, input int k);
      voxel_cmd_type c;
      c = scrambled_cmd();
      c.kind      = KIND_READ;
      c.read_type = TYPE_W'(t);
      c.read_i    = IDX_W'(i);
      c.read_j    = IDX_W'(j);
      c.read_k    = IDX_W'(k);
      return c;
   endfunction

   // cell choice: mostly a hot cluster, some at the grid faces, some anywhere
   function automatic int pick_cell();
      int r;
      r = $urandom_range(99);
      if (r < 60) return HOT_LO + int'($urandom_range(5));
      if (r < 70) return int'($urandom_range(3)) - 2;
      if (r < 80) return GRID - 2 + int'($urandom_range(3));
      return int'($urandom_range(GRID + 3)) - 2;
   endfunction

   function automatic int pick_coord(input int c);
      if ($urandom_range(9) == 0) return c * CELL_ONE;
      return c * CELL_ONE + int'($urandom_range(CELL_ONE - 1));
   endfunction

   function automatic int near_index(input int v);
      int r;
      r = v + int'($urandom_range(2 * RADIUS)) - RADIUS;
      return (r < 0) ? 0 : (r >= GRID) ? GRID - 1 : r;
   endfunction

   // read aimed at a recent atom so the voxel is usually nonzero
   function automatic voxel_cmd_type aimed_read();
      site_type s;
      if (recent_sites.size() == 0 || $urandom_range(4) == 0)
         return read_at($urandom_range(TYPES - 1), $urandom_range(GRID - 1),
                        $urandom_range(GRID - 1), $urandom_range(GRID - 1));
      s = recent_sites[$urandom_range(recent_sites.size() - 1)];
      return read_at(s.t, near_index(s.x), near_index(s.y), near_index(s.z));
   endfunction

   // random beat: well-formed splats and aimed reads, plus raw noise
   function automatic voxel_cmd_type random_cmd();
      voxel_cmd_type c;
      site_type s;
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         s.t = $urandom_range(TYPES - 1);
         s.x = pick_cell();
         s.y = pick_cell();
         s.z = pick_cell();
         recent_sites.push_back(s);
         if (recent_sites.size() > 8) void'(recent_sites.pop_front());
         c = splat_at(s.t, pick_coord(s.x), pick_coord(s.y), pick_coord(s.z));
      end else if (roll < 85) begin
         c = aimed_read();
      end else begin
         c = scrambled_cmd();
         c.kind = (roll < 92) ? KIND_SPLAT : KIND_READ;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [VOXEL_W-1:0] got,
                                  input logic [VOXEL_W-1:0] want);
      mismatch_count++;
      $display("%0t: rsp mismatch, %s: got %h want %h", $time, what, got, want);
   endtask

   task automatic wait_for_drain();
      while (pending_beats.size() > 0 || req_valid) @(negedge clock);
   endtask

   task automatic run_phase(input phase_type p, input int send_pct, input int stall_pct,
                            input int count);
      int n;
      @(negedge clock);
      phase = p;
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         if (p == PH_PRESSURE) pending_beats.push_back(aimed_read());
         else pending_beats.push_back(random_cmd());
      end
      wait_for_drain();
   endtask

   // request driver: retire the accepted beat into the mirror, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (on_bus.kind == KIND_SPLAT) begin
               deposit_atom(on_bus.splat_grid, on_bus.pos_x, on_bus.pos_y, on_bus.pos_z);
               splats_accepted++;
            end else begin
               expected_voxels.push_back(lookup_voxel(on_bus));
               reads_accepted++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_beats.pop_front();
               req_valid      <= 1'b1;
               req_kind       <= on_bus.kind;
               req_splat_grid <= on_bus.splat_grid;
               req_pos_x      <= on_bus.pos_x;
               req_pos_y      <= on_bus.pos_y;
               req_pos_z      <= on_bus.pos_z;
               req_read_type  <= on_bus.read_type;
               req_read_i     <= on_bus.read_i;
               req_read_j     <= on_bus.read_j;
               req_read_k     <= on_bus.read_k;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: long hold-off at the start of the pressure phase, else random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
      end else if (phase == PH_PRESSURE && hold_cnt < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= hold_cnt + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (phase != PH_PRESSURE) hold_cnt <= 0;
      end
   end

   // result monitor: compare each beat with the oldest expected voxel
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_voxels.size() == 0) begin
            report_mismatch("result with no read outstanding", rsp_voxel_value, '0);
         end else begin
            voxel_want = expected_voxels.pop_front();
            voxels_checked++;
            if (rsp_voxel_value !== voxel_want)
               report_mismatch("voxel_value", rsp_voxel_value, voxel_want);
            else if (voxel_want == VOXEL_MAX)
               saturated_seen++;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("atom_gaussian_voxel_splat_core_tb: done, errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [63:0] chain, w;
      int n, hot_t, hot_x, hot_y, hot_z;

      // exp(-n/32) in Q0.16 from a rounded Q0.32 decay chain
      chain = 64'h1_0000_0000;
      for (n = 0; n < WEIGHT_DEPTH; n++) begin
         w = (chain + 64'd32768) >> 16;
         gauss_weight[n] = (w > 64'hFFFF) ? '1 : w[WEIGHT_W-1:0];
         chain = (chain * DECAY_Q32 + 64'h8000_0000) >> 32;
      end

      // untouched store reads zero
      pending_beats.push_back(read_at(0, 0, 0, 0));
      // corner atom on a grid point: zero distance weight saturates, most cells off grid
      pending_beats.push_back(splat_at(0, 0, 0, 0));
      pending_beats.push_back(read_at(0, 0, 0, 0));
      pending_beats.push_back(read_at(0, 0, 0, 1));
      pending_beats.push_back(read_at(0, 2, 2, 2));
      pending_beats.push_back(read_at(0, 3, 0, 0));
      // extremes of the position range, whole neighborhood off grid
      pending_beats.push_back(splat_at(TYPES - 1, 32767, 32767, 32767));
      pending_beats.push_back(splat_at(TYPES - 1, -32768, -32768, -32768));
      // straddling the upper faces and the lower z face
      pending_beats.push_back(splat_at(TYPES - 1, 31 * CELL_ONE + 128, 31 * CELL_ONE + 255, -1));
      pending_beats.push_back(read_at(TYPES - 1, 31, 31, 0));
      pending_beats.push_back(read_at(TYPES - 1, 29, 30, 1));
      pending_beats.push_back(read_at(TYPES - 1, 31, 31, 31));
      // splat types past the last grid are dropped, reads of them return zero
      pending_beats.push_back(splat_at(TYPES, 5 * CELL_ONE, 5 * CELL_ONE, 5 * CELL_ONE));
      pending_beats.push_back(splat_at(15, 5 * CELL_ONE, 5 * CELL_ONE, 5 * CELL_ONE));
      pending_beats.push_back(read_at(TYPES - 1, 5, 5, 5));
      pending_beats.push_back(read_at(TYPES, 5, 5, 5));
      pending_beats.push_back(read_at(15, 31, 31, 31));
      // fractional position, reads at the rim of the neighborhood
      pending_beats.push_back(splat_at(5, 8 * CELL_ONE + 255, 8 * CELL_ONE + 1,
                                       8 * CELL_ONE + 128));
      pending_beats.push_back(read_at(5, 8, 8, 8));
      pending_beats.push_back(read_at(5, 10, 6, 10));
      pending_beats.push_back(read_at(5, 6, 10, 6));
      pending_beats.push_back(read_at(5, 9, 8, 7));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      // one grid point hit until its voxel pins at full scale
      hot_t = $urandom_range(TYPES - 1);
      hot_x = $urandom_range(GRID - 5, 4);
      hot_y = $urandom_range(GRID - 5, 4);
      hot_z = $urandom_range(GRID - 5, 4);
      for (n = 0; n < 290; n++) begin
         pending_beats.push_back(splat_at(hot_t, hot_x * CELL_ONE, hot_y * CELL_ONE,
                                          hot_z * CELL_ONE));
         if (n % 29 == 28) pending_beats.push_back(read_at(hot_t, hot_x, hot_y, hot_z));
      end
      pending_beats.push_back(read_at(hot_t, hot_x + 1, hot_y, hot_z));
      pending_beats.push_back(read_at(hot_t, hot_x, hot_y - 2, hot_z + 2));
      wait_for_drain();

      // random traffic under each idling pattern
      run_phase(PH_STEADY, 0, 0, 220);
      run_phase(PH_SEND_GAPS, 45, 0, 220);
      run_phase(PH_PRESSURE, 0, 0, 40);
      run_phase(PH_RECV_STALLS, 0, 45, 220);
      run_phase(PH_BOTH_IDLE, 14, 14, 220);

      // drain results, then let the last splat finish
      while (expected_voxels.size() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("splat core run: %0d splat beats and %0d read beats accepted, %0d voxels checked",
               splats_accepted, reads_accepted, voxels_checked);
      $display("saturated voxels read back: %0d, mismatches: %0d", saturated_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("atom_gaussian_voxel_splat_core_tb: done, clean");
      end else begin
         $display("atom_gaussian_voxel_splat_core_tb: done, errors");
      end
      $finish;
   end

endmodule
